[rtl/core/tcpu_pkg.sv]
// Shared types, codes and constants of the toy CPU fetch and execute unit.
package tcpu_pkg;

    localparam int unsigned MemDepth = 65536;
    localparam int unsigned AddrW    = $clog2(MemDepth);

    localparam logic [15:0] START_RESET = 16'h03E7;
    localparam logic [15:0] STACK_RESET = 16'hEA60;

    // Configuration register indexes.
    localparam logic [7:0] CFG_START = 8'd0;
    localparam logic [7:0] CFG_STACK = 8'd1;

    // Opcodes.
    localparam logic [7:0] OP_HLT = 8'h0A;
    localparam logic [7:0] OP_SHW = 8'h0B;
    localparam logic [7:0] OP_MOV = 8'h2A;
    localparam logic [7:0] OP_LDA = 8'h2B;
    localparam logic [7:0] OP_STA = 8'h2C;
    localparam logic [7:0] OP_ADD = 8'h1A;
    localparam logic [7:0] OP_SUB = 8'h1B;
    localparam logic [7:0] OP_MUL = 8'h1C;
    localparam logic [7:0] OP_DIV = 8'h1D;
    localparam logic [7:0] OP_CMP = 8'h3A;
    localparam logic [7:0] OP_CMZ = 8'h3B;
    localparam logic [7:0] OP_CMS = 8'h3C;
    localparam logic [7:0] OP_JMP = 8'h4A;
    localparam logic [7:0] OP_JMZ = 8'h4B;
    localparam logic [7:0] OP_JMS = 8'h4C;
    localparam logic [7:0] OP_PSH = 8'h5A;
    localparam logic [7:0] OP_POP = 8'h5B;
    localparam logic [7:0] OP_WRT = 8'h6A;

    // Register codes in operand bytes.
    localparam logic [7:0] RC_AX = 8'hF0;
    localparam logic [7:0] RC_BX = 8'hF1;
    localparam logic [7:0] RC_CX = 8'hF2;
    localparam logic [7:0] RC_DX = 8'hF3;

    // Result status codes.
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_HALT = 3'd1;
    localparam logic [2:0] ST_CHAR = 3'd2;
    localparam logic [2:0] ST_SHOW = 3'd3;
    localparam logic [2:0] ST_ILL  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_OP, S_OPND, S_EXEC, S_MEMRD, S_MUL, S_DIV, S_RESP
    } t_state;

    function automatic logic is_reg(input logic [7:0] code);
        return code[7:2] == RC_AX[7:2];
    endfunction

    // Memory contents after reset: the opcode table and two data bytes.
    function automatic logic [7:0] init_byte(input logic [AddrW-1:0] a);
        logic [7:0] v;
        v = 8'h00;
        case (a)
            16'd0:  v = OP_HLT;
            16'd1:  v = OP_SHW;
            16'd2:  v = OP_MOV;
            16'd3:  v = OP_LDA;
            16'd4:  v = OP_STA;
            16'd5:  v = OP_ADD;
            16'd6:  v = OP_SUB;
            16'd7:  v = OP_MUL;
            16'd8:  v = OP_DIV;
            16'd9:  v = OP_CMP;
            16'd10: v = OP_CMZ;
            16'd11: v = OP_CMS;
            16'd12: v = OP_JMP;
            16'd13: v = OP_JMZ;
            16'd14: v = OP_JMS;
            16'd15: v = OP_PSH;
            16'd16: v = OP_POP;
            16'd17: v = OP_WRT;
            16'h0164: v = 8'd71;
            16'h0170: v = 8'd9;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/toy_cpu_fetch_execute_unit.sv]
// Top level of the toy CPU: byte memory, register file, sequencer and shared adder.
//
//  Channel | Direction | Handshake            | Payload
//  input   | in        | i_valid / o_stall    | req_type, load_address, load_data
//  result  | out       | o_valid / i_stall    | status, out_char, registers, pc, sp, flags
//  config  | in        | i_cfg_valid / ready  | cfg_index, cfg_data
//
// A step's length is set by its operand fetches through the single memory port, and grows
// further when MUL or DIV iterate on the one shared adder.
// After reset a clearing pass writes the memory image into all 65536 bytes; no item is taken
// meanwhile. Reset is synchronous and active low. The block holds o_stall high from a
// transfer in until its result has been transferred out.
module toy_cpu_fetch_execute_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_req_type,
    input  logic [15:0]         i_load_address,
    input  logic [7:0]          i_load_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [7:0]          o_out_char,
    output logic signed [15:0]  o_a_value,
    output logic signed [15:0]  o_b_value,
    output logic signed [15:0]  o_c_value,
    output logic signed [15:0]  o_d_value,
    output logic [15:0]         o_pc_value,
    output logic [15:0]         o_sp_value,
    output logic                o_zero_out,
    output logic                o_sign_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import tcpu_pkg::*;

    logic [7:0] r_mem [MemDepth];
    logic [7:0] r_rdata;

    t_state r_state, n_state;
    logic [15:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic [15:0] r_pc, r_sp, n_pc, n_sp;
    logic        r_z, r_s, r_halt, n_z, n_s, n_halt;
    logic [7:0]  r_op, r_b1, r_b2, r_b3, n_op, n_b1, n_b2, n_b3;
    logic [1:0]  r_cnt, r_need, n_cnt, n_need;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_char, n_char;
    logic [15:0] r_clr, n_clr;
    logic [15:0] r_acc, r_m, r_n, n_acc, n_m, n_n;
    logic [15:0] r_rem, r_quo, r_dvs, n_rem, n_quo, n_dvs;
    logic [3:0]  r_step, n_step;

    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wd;

    logic [15:0] alu_x, alu_y;
    logic        alu_sub;
    logic [16:0] alu_r;

    logic        wr_en;
    logic [7:0]  wr_code;
    logic [15:0] wr_val;

    logic [15:0] reg_d1, reg_s2, cval, dvv, rem_sh;
    logic        in_acc;

    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_RESP);
    assign o_cfg_ready = 1'b1;
    assign o_status    = r_status;
    assign o_out_char  = r_char;
    assign o_a_value   = $signed(r_a);
    assign o_b_value   = $signed(r_b);
    assign o_c_value   = $signed(r_c);
    assign o_d_value   = $signed(r_d);
    assign o_pc_value  = r_pc;
    assign o_sp_value  = r_sp;
    assign o_zero_out  = r_z;
    assign o_sign_out  = r_s;

    // The shared adder: subtracts when alu_sub is set; carry out means no borrow.
    assign alu_r = {1'b0, alu_x} + {1'b0, alu_sub ? ~alu_y : alu_y} + {16'd0, alu_sub};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_comb begin
        case (r_b1)
            RC_AX:   reg_d1 = r_a;
            RC_BX:   reg_d1 = r_b;
            RC_CX:   reg_d1 = r_c;
            default: reg_d1 = r_d;
        endcase
        case (r_b2)
            RC_AX:   reg_s2 = r_a;
            RC_BX:   reg_s2 = r_b;
            RC_CX:   reg_s2 = r_c;
            RC_DX:   reg_s2 = r_d;
            default: reg_s2 = {8'h00, r_b2};
        endcase
        if (r_b2 == RC_AX) begin
            cval = r_a;
        end else if (r_b2 == RC_BX) begin
            cval = r_b;
        end else begin
            cval = {8'h00, r_b2};
        end
        if (r_b1 == RC_AX) begin
            dvv = (r_b2 == RC_BX) ? r_b : {8'h00, r_b2};
        end else begin
            dvv = (r_b2 == RC_AX) ? r_a : {8'h00, r_b2};
        end
        rem_sh = {r_rem[14:0], r_quo[15]};
    end

    always_comb begin
        n_state = r_state;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        n_pc = r_pc; n_sp = r_sp;
        n_z = r_z; n_s = r_s; n_halt = r_halt;
        n_op = r_op; n_b1 = r_b1; n_b2 = r_b2; n_b3 = r_b3;
        n_cnt = r_cnt; n_need = r_need;
        n_status = r_status; n_char = r_char;
        n_clr = r_clr;
        n_acc = r_acc; n_m = r_m; n_n = r_n;
        n_rem = r_rem; n_quo = r_quo; n_dvs = r_dvs; n_step = r_step;
        mem_we = 1'b0; mem_addr = r_pc + 16'd1; mem_wd = 8'h00;
        alu_x = 16'd0; alu_y = 16'd0; alu_sub = 1'b0;
        wr_en = 1'b0; wr_code = r_b1; wr_val = 16'd0;

        case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                mem_wd   = init_byte(r_clr);
                n_clr    = r_clr + 16'd1;
                if (r_clr == 16'hFFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_OK;
                    n_char   = 8'h00;
                    if (!i_req_type) begin
                        mem_we   = 1'b1;
                        mem_addr = i_load_address;
                        mem_wd   = i_load_data;
                        n_state  = S_RESP;
                    end else if (r_halt) begin
                        n_status = ST_HALT;
                        n_state  = S_RESP;
                    end else begin
                        n_pc    = r_pc + 16'd1;
                        n_state = S_OP;
                    end
                end
            end
            S_OP: begin
                n_op  = r_rdata;
                n_cnt = 2'd0;
                case (r_rdata)
                    OP_HLT, OP_SHW, OP_CMZ, OP_CMS, OP_PSH, OP_POP: begin
                        n_state = S_EXEC;
                    end
                    OP_JMP, OP_JMZ, OP_JMS, OP_WRT: begin
                        n_need = 2'd1; n_pc = r_pc + 16'd1; n_state = S_OPND;
                    end
                    OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
                        n_need = 2'd2; n_pc = r_pc + 16'd1; n_state = S_OPND;
                    end
                    OP_LDA, OP_STA: begin
                        n_need = 2'd3; n_pc = r_pc + 16'd1; n_state = S_OPND;
                    end
                    default: begin
                        n_status = ST_ILL;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_OPND: begin
                case (r_cnt)
                    2'd0:    n_b1 = r_rdata;
                    2'd1:    n_b2 = r_rdata;
                    default: n_b3 = r_rdata;
                endcase
                if (r_cnt + 2'd1 == r_need) begin
                    n_state = S_EXEC;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                    n_pc  = r_pc + 16'd1;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_op)
                    OP_HLT: begin
                        n_halt = 1'b1; n_status = ST_HALT;
                    end
                    OP_SHW: n_status = ST_SHOW;
                    OP_MOV: begin
                        wr_code = (r_b1 == RC_AX || r_b1 == RC_BX || r_b1 == RC_CX)
                                  ? r_b1 : RC_DX;
                        wr_en   = is_reg(r_b2) && (r_b2 != wr_code);
                        wr_val  = reg_s2;
                    end
                    OP_LDA: begin
                        if (is_reg(r_b1)) begin
                            mem_addr = {r_b2, r_b3};
                            n_state  = S_MEMRD;
                        end
                    end
                    OP_STA: begin
                        mem_addr = {r_b2, r_b3};
                        mem_wd   = reg_d1[7:0];
                        mem_we   = is_reg(r_b1);
                    end
                    OP_ADD, OP_SUB: begin
                        alu_x   = reg_d1;
                        alu_y   = reg_s2;
                        alu_sub = (r_op == OP_SUB);
                        wr_en   = is_reg(r_b1);
                        wr_val  = alu_r[15:0];
                    end
                    OP_MUL: begin
                        n_c = cval;
                        if (r_b1 == RC_AX || r_b1 == RC_BX) begin
                            n_d = reg_d1;
                            if (!cval[15] && cval > 16'd1) begin
                                alu_x   = cval;
                                alu_y   = 16'd1;
                                alu_sub = 1'b1;
                                n_n     = alu_r[15:0];
                                n_acc   = reg_d1;
                                n_m     = reg_d1;
                                n_step  = 4'd0;
                                n_state = S_MUL;
                            end
                        end
                    end
                    OP_DIV: begin
                        if (r_b1 != RC_AX && r_b1 != RC_BX) begin
                            n_c = 16'd0;
                        end else if (dvv[15] || dvv == 16'd0) begin
                            n_status = ST_DIV;
                        end else if (reg_d1[15]) begin
                            // A negative dividend leaves a zero quotient.
                            n_c    = 16'd0;
                            n_d    = reg_d1;
                            wr_en  = 1'b1;
                            wr_val = 16'd0;
                        end else begin
                            n_rem   = 16'd0;
                            n_quo   = reg_d1;
                            n_dvs   = dvv;
                            n_step  = 4'd0;
                            n_state = S_DIV;
                        end
                    end
                    OP_CMP: begin
                        wr_en   = 1'b1;
                        wr_code = RC_DX;
                        if (r_b1 == RC_AX && r_b2 == RC_BX) begin
                            wr_val = {15'd0, r_a == r_b};
                        end else if (r_b1 == RC_AX) begin
                            wr_val = {15'd0, r_a == r_c};
                        end else begin
                            wr_val = {15'd0, r_b == r_c};
                        end
                    end
                    OP_CMZ: begin
                        wr_en = 1'b1; wr_code = RC_DX; wr_val = {15'd0, r_z};
                    end
                    OP_CMS: begin
                        wr_en = 1'b1; wr_code = RC_DX; wr_val = {15'd0, r_s};
                    end
                    OP_JMP, OP_JMZ, OP_JMS: begin
                        alu_x   = r_pc;
                        alu_y   = {{8{r_b1[7]}}, r_b1};
                        alu_sub = 1'b1;
                        if (r_op == OP_JMP || (r_op == OP_JMZ && r_z) ||
                            (r_op == OP_JMS && r_s)) begin
                            n_pc = alu_r[15:0];
                        end
                    end
                    OP_PSH: begin
                        mem_we   = 1'b1;
                        mem_addr = r_sp;
                        mem_wd   = r_d[7:0];
                        n_sp     = r_sp + 16'd1;
                    end
                    OP_POP: begin
                        mem_addr = r_sp - 16'd1;
                        n_sp     = r_sp - 16'd1;
                        n_b1     = RC_DX;
                        n_state  = S_MEMRD;
                    end
                    OP_WRT: begin
                        n_status = ST_CHAR;
                        n_char   = r_b1;
                    end
                    default: n_status = ST_ILL;
                endcase
            end
            S_MEMRD: begin
                wr_en   = 1'b1;
                wr_val  = {8'h00, r_rdata};
                n_state = S_RESP;
            end
            S_MUL: begin
                // Shift-and-add: adds the multiplicand for each set multiplier bit.
                alu_x  = r_acc;
                alu_y  = r_m;
                n_acc  = r_n[0] ? alu_r[15:0] : r_acc;
                n_m    = {r_m[14:0], 1'b0};
                n_n    = {1'b0, r_n[15:1]};
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    n_c     = 16'd1;
                    wr_en   = 1'b1;
                    wr_val  = n_acc;
                    n_state = S_RESP;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit a cycle.
                alu_x   = rem_sh;
                alu_y   = r_dvs;
                alu_sub = 1'b1;
                n_rem   = alu_r[16] ? alu_r[15:0] : rem_sh;
                n_quo   = {r_quo[14:0], alu_r[16]};
                n_step  = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    n_c     = n_quo;
                    n_d     = n_rem;
                    wr_en   = 1'b1;
                    wr_val  = n_quo;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (wr_en) begin
            case (wr_code)
                RC_AX: begin
                    n_a = wr_val;
                    n_z = (wr_val == 16'd0);
                    n_s = wr_val[15];
                end
                RC_BX:   n_b = wr_val;
                RC_CX:   n_c = wr_val;
                RC_DX:   n_d = wr_val;
                default: n_d = r_d;
            endcase
        end

        // A configuration write reloads the program counter or the stack pointer.
        if (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_START) begin
            n_pc = i_cfg_data;
        end
        if (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_STACK) begin
            n_sp = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= 16'd0;
            r_a      <= 16'd0;
            r_b      <= 16'd0;
            r_c      <= 16'd0;
            r_d      <= 16'd0;
            r_pc     <= START_RESET;
            r_sp     <= STACK_RESET;
            r_z      <= 1'b0;
            r_s      <= 1'b0;
            r_halt   <= 1'b0;
            r_status <= ST_OK;
            r_char   <= 8'h00;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_a      <= n_a;
            r_b      <= n_b;
            r_c      <= n_c;
            r_d      <= n_d;
            r_z      <= n_z;
            r_s      <= n_s;
            r_halt   <= n_halt;
            r_status <= n_status;
            r_char   <= n_char;
            r_pc     <= n_pc;
            r_sp     <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_b3   <= n_b3;
        r_cnt  <= n_cnt;
        r_need <= n_need;
        r_acc  <= n_acc;
        r_m    <= n_m;
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_step <= n_step;
    end

endmodule

[rtl/core/tcpu_checker.sv]
// Port-level checks of the toy CPU unit and their binding to the top level.
module tcpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [7:0]  o_out_char
);
    import tcpu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");

    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result is pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after an input transfer");

    a_char_only_wrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_CHAR |-> o_out_char == 8'h00)
        else $error("character shown without a write");

endmodule

bind toy_cpu_fetch_execute_unit tcpu_checker u_tcpu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_out_char (o_out_char)
);

[bench/tb_top.sv]
// Self-checking testbench for the toy CPU fetch and execute unit.
`timescale 1ns / 100ps

module tb_top;
    import tcpu_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  out_char;
        logic [15:0] a_value;
        logic [15:0] b_value;
        logic [15:0] c_value;
        logic [15:0] d_value;
        logic [15:0] pc_value;
        logic [15:0] sp_value;
        logic        zero_out;
        logic        sign_out;
    } t_cpu_view;

    typedef struct {
        logic        req;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        typed;
        logic [2:0]  status;
    } t_stim_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_req_type;
    logic [15:0] i_load_address;
    logic [7:0] i_load_data;
    logic o_valid, i_stall;
    logic [2:0] o_status;
    logic [7:0] o_out_char;
    logic signed [15:0] o_a_value, o_b_value, o_c_value, o_d_value;
    logic [15:0] o_pc_value, o_sp_value;
    logic o_zero_out, o_sign_out;
    logic i_cfg_valid, o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    toy_cpu_fetch_execute_unit uut (.*);

    // Shadow copy of the CPU.
    logic [7:0] mem_img [0:65535];
    logic [15:0] ax, bx, cx, dx, pc, sp;
    logic zf, sf, hlt;

    t_cpu_view expected_views[$];
    logic [7:0] op_list [0:17];
    int errs = 0;
    int n_in = 0;
    int n_out = 0;
    int n_cfg = 0;
    bit calm = 0;

    initial begin
        i_clk = 0;
    end
    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic logic is_rc(logic [7:0] c);
        return c >= RC_AX && c <= RC_DX;
    endfunction

    function automatic logic [15:0] reg_get(logic [7:0] c);
        case (c)
            RC_AX: return ax;
            RC_BX: return bx;
            RC_CX: return cx;
            RC_DX: return dx;
            default: return 16'h0;
        endcase
    endfunction

    // Writes to AX are the only thing that moves the flags.
    function automatic void reg_put(logic [7:0] c, logic [15:0] v);
        case (c)
            RC_AX: begin
                ax = v;
                zf = (v == 16'h0);
                sf = v[15];
            end
            RC_BX: bx = v;
            RC_CX: cx = v;
            RC_DX: dx = v;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] fetch_byte();
        pc = pc + 16'd1;
        return mem_img[pc];
    endfunction

    function automatic logic [2:0] exec_instr(output logic [7:0] ch);
        logic [7:0] op, d, s, hi, lo, tgt, b;
        int dv, x;
        ch = 8'h0;
        op = fetch_byte();
        case (op)
            OP_HLT: begin
                hlt = 1;
                return ST_HALT;
            end
            OP_SHW: return ST_SHOW;
            OP_MOV: begin
                d = fetch_byte();
                s = fetch_byte();
                tgt = (d == RC_AX || d == RC_BX || d == RC_CX) ? d : RC_DX;
                if (is_rc(s) && s != tgt) reg_put(tgt, reg_get(s));
            end
            OP_LDA, OP_STA: begin
                d = fetch_byte();
                hi = fetch_byte();
                lo = fetch_byte();
                if (is_rc(d)) begin
                    if (op == OP_LDA) reg_put(d, {8'h0, mem_img[{hi, lo}]});
                    else mem_img[{hi, lo}] = 8'(reg_get(d));
                end
            end
            OP_ADD, OP_SUB: begin
                d = fetch_byte();
                s = fetch_byte();
                if (is_rc(d)) begin
                    if (op == OP_ADD)
                        reg_put(d, reg_get(d) + (is_rc(s) ? reg_get(s) : {8'h0, s}));
                    else
                        reg_put(d, reg_get(d) - (is_rc(s) ? reg_get(s) : {8'h0, s}));
                end
            end
            OP_MUL: begin
                d = fetch_byte();
                s = fetch_byte();
                cx = (s == RC_AX) ? ax : (s == RC_BX) ? bx : {8'h0, s};
                if (d == RC_AX || d == RC_BX) begin
                    dx = reg_get(d);
                    if ($signed(cx) > 16'sd1) begin
                        reg_put(d, reg_get(d) + 16'((cx - 16'd1) * dx));
                        cx = 16'd1;
                    end
                end
            end
            OP_DIV: begin
                d = fetch_byte();
                s = fetch_byte();
                if (d == RC_AX) dv = (s == RC_BX) ? int'($signed(bx)) : int'(s);
                else if (d == RC_BX) dv = (s == RC_AX) ? int'($signed(ax)) : int'(s);
                else begin
                    cx = 16'h0;
                    return ST_OK;
                end
                if (dv <= 0) return ST_DIV;
                x = int'($signed(reg_get(d)));
                if (x >= dv) begin
                    cx = 16'(x / dv);
                    dx = 16'(x % dv);
                end else begin
                    cx = 16'h0;
                    dx = reg_get(d);
                end
                reg_put(d, cx);
            end
            OP_CMP: begin
                d = fetch_byte();
                s = fetch_byte();
                if (d == RC_AX && s == RC_BX) dx = {15'h0, ax == bx};
                else if (d == RC_AX) dx = {15'h0, ax == cx};
                else dx = {15'h0, bx == cx};
            end
            OP_CMZ: dx = {15'h0, zf};
            OP_CMS: dx = {15'h0, sf};
            OP_JMP, OP_JMZ, OP_JMS: begin
                b = fetch_byte();
                if (op == OP_JMP || (op == OP_JMZ && zf) || (op == OP_JMS && sf))
                    pc = pc - {{8{b[7]}}, b};
            end
            OP_PSH: begin
                mem_img[sp] = dx[7:0];
                sp = sp + 16'd1;
            end
            OP_POP: begin
                sp = sp - 16'd1;
                dx = {8'h0, mem_img[sp]};
            end
            OP_WRT: begin
                ch = fetch_byte();
                return ST_CHAR;
            end
            default: return ST_ILL;
        endcase
        return ST_OK;
    endfunction

    function automatic t_cpu_view predict_item(logic req, logic [15:0] addr,
                                               logic [7:0] data);
        t_cpu_view v;
        logic [7:0] ch;
        ch = 8'h0;
        v.status = ST_OK;
        if (!req) mem_img[addr] = data;
        else if (hlt) v.status = ST_HALT;
        else v.status = exec_instr(ch);
        v.out_char = (v.status == ST_CHAR) ? ch : 8'h0;
        v.a_value = ax;
        v.b_value = bx;
        v.c_value = cx;
        v.d_value = dx;
        v.pc_value = pc;
        v.sp_value = sp;
        v.zero_out = zf;
        v.sign_out = sf;
        return v;
    endfunction

    // Drives one item; valid stays high on return so back-to-back items need no gap.
    task automatic send_item(logic req, logic [15:0] addr, logic [7:0] data,
                             logic typed = 0, logic [2:0] st = ST_OK);
        t_cpu_view v;
        if (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_load_address <= addr;
        i_load_data <= data;
        do @(posedge i_clk); while (o_stall);
        v = predict_item(req, addr, data);
        if (typed) v.status = st;
        expected_views.push_back(v);
        n_in++;
    endtask

    function automatic logic [7:0] operand_byte();
        if ($urandom_range(99) < 60) return RC_AX + 8'($urandom_range(3));
        return 8'($urandom);
    endfunction

    // Places an instruction right after the program counter, then executes it.
    task automatic run_instr(logic [7:0] op, logic [7:0] o1, logic [7:0] o2,
                             logic [7:0] o3);
        logic [15:0] base;
        base = pc;
        send_item(1'b0, base + 16'd1, op);
        send_item(1'b0, base + 16'd2, o1);
        send_item(1'b0, base + 16'd3, o2);
        send_item(1'b0, base + 16'd4, o3);
        send_item(1'b1, 16'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START) pc = val;
        else if (idx == CFG_STACK) sp = val;
        n_cfg++;
    endtask

    task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cpu_view e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_views.size() == 0) begin
                $error("result transfer with nothing expected");
                errs++;
            end else begin
                e = expected_views.pop_front();
                check_field("status", e.status, o_status);
                check_field("out_char", e.out_char, o_out_char);
                check_field("a_value", e.a_value, o_a_value);
                check_field("b_value", e.b_value, o_b_value);
                check_field("c_value", e.c_value, o_c_value);
                check_field("d_value", e.d_value, o_d_value);
                check_field("pc_value", e.pc_value, o_pc_value);
                check_field("sp_value", e.sp_value, o_sp_value);
                check_field("zero_out", e.zero_out, o_zero_out);
                check_field("sign_out", e.sign_out, o_sign_out);
                n_out++;
            end
        end
        i_stall <= !calm && ($urandom_range(99) < 13);
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_stim_row rows [$];
        logic [15:0] starts [4];
        logic [15:0] stacks [4];
        logic [7:0] op;
        int budget;

        op_list = '{OP_HLT, OP_SHW, OP_MOV, OP_LDA, OP_STA, OP_ADD, OP_SUB, OP_MUL,
                    OP_DIV, OP_CMP, OP_CMZ, OP_CMS, OP_JMP, OP_JMZ, OP_JMS, OP_PSH,
                    OP_POP, OP_WRT};
        foreach (mem_img[k]) mem_img[k] = 8'h0;
        foreach (op_list[k]) mem_img[k] = op_list[k];
        mem_img[16'h0164] = 8'd71;
        mem_img[16'h0170] = 8'd9;
        ax = 0; bx = 0; cx = 0; dx = 0;
        pc = START_RESET;
        sp = STACK_RESET;
        zf = 0; sf = 0; hlt = 0;

        i_rst_n = 0;
        i_valid = 0;
        i_req_type = 0;
        i_load_address = 0;
        i_load_data = 0;
        i_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zeroed memory at the first opcode is illegal; the rest runs a short program.
        rows = '{
            '{1'b1, 16'h0000, 8'h00, 1'b1, ST_ILL},
            '{1'b0, 16'hFFFF, 8'hFF, 1'b1, ST_OK},
            '{1'b0, 16'h0170, 8'h00, 1'b1, ST_OK},
            '{1'b0, 16'd1001, OP_SHW, 1'b1, ST_OK},
            '{1'b1, 16'hFFFF, 8'hFF, 1'b1, ST_SHOW},
            '{1'b0, 16'd1002, OP_WRT, 1'b0, ST_OK},
            '{1'b0, 16'd1003, 8'hFF, 1'b0, ST_OK},
            '{1'b1, 16'h0000, 8'h00, 1'b1, ST_CHAR},
            '{1'b0, 16'd1004, OP_DIV, 1'b0, ST_OK},
            '{1'b0, 16'd1005, RC_AX, 1'b0, ST_OK},
            '{1'b0, 16'd1006, 8'h00, 1'b0, ST_OK},
            '{1'b1, 16'h0000, 8'h00, 1'b1, ST_DIV},
            '{1'b0, 16'd1007, OP_LDA, 1'b0, ST_OK},
            '{1'b0, 16'd1008, RC_AX, 1'b0, ST_OK},
            '{1'b0, 16'd1009, 8'hFF, 1'b0, ST_OK},
            '{1'b0, 16'd1010, 8'hFF, 1'b0, ST_OK},
            '{1'b1, 16'h0000, 8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd1011, OP_PSH, 1'b0, ST_OK},
            '{1'b1, 16'h0000, 8'h00, 1'b0, ST_OK},
            '{1'b0, 16'd1012, OP_POP, 1'b0, ST_OK},
            '{1'b1, 16'h0000, 8'h00, 1'b0, ST_OK}
        };
        foreach (rows[k])
            send_item(rows[k].req, rows[k].addr, rows[k].data, rows[k].typed,
                      rows[k].status);
        i_valid <= 1'b0;

        starts = '{16'h0000, 16'hFFFF, 16'($urandom), 16'hFFF0};
        stacks = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8000};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_START, starts[ph]);
            write_reg(CFG_STACK, stacks[ph]);
            budget = n_in + 175;
            while (n_in < budget) begin
                calm = (ph == 2) && (n_in < budget - 60);
                if ($urandom_range(99) < 10) begin
                    send_item(1'b0, 16'($urandom), 8'($urandom));
                end else begin
                    if ($urandom_range(99) < 90) op = op_list[$urandom_range(17, 1)];
                    else do op = 8'($urandom); while (op == OP_HLT);
                    run_instr(op, operand_byte(), operand_byte(), operand_byte());
                end
            end
            calm = 0;
            i_valid <= 1'b0;
        end

        // Halting is permanent, so it comes last.
        run_instr(OP_HLT, 8'h00, 8'h00, 8'h00);
        send_item(1'b1, 16'h0000, 8'h00, 1'b1, ST_HALT);
        send_item(1'b0, 16'h0200, 8'h5A);
        send_item(1'b1, 16'h0000, 8'h00, 1'b1, ST_HALT);
        i_valid <= 1'b0;

        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("tb: %0d items sent, %0d results checked, %0d register writes",
                 n_in, n_out, n_cfg);
        $display("tb: all opcodes, illegal and divide-error cases, wraps and halt covered");
        if (errs == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tcpu_pkg.sv
rtl/core/toy_cpu_fetch_execute_unit.sv
rtl/core/tcpu_checker.sv
bench/tb_top.sv
